@@ rtl/sound_cpu_bus_controller_defines.svh @@
// ----------------------------------------------------------------------------
// sound cpu bus controller assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef SOUND_CPU_BUS_CONTROLLER_DEFINES_SVH
`define SOUND_CPU_BUS_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SCBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SCBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/scbc_pkg.sv @@
// ----------------------------------------------------------------------------
// scbc_pkg
// types and constants shared by the sound cpu bus controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scbc_pkg;

	localparam int RAM_BYTES  = 8192;
	localparam int BANK_BYTES = 16384;
	localparam int RAM_AW     = $clog2(RAM_BYTES);

	localparam int LIN_W      = $clog2(15 * BANK_BYTES + 16384);
	localparam int ROM_SIZE_W = 21;
	localparam int OFFSET_W   = 20;
	localparam int CNT_W      = $clog2(LIN_W + 1);

	localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_MAX = 21'h100000;
	localparam logic [15:0]           RAM_MASK     = 16'h1fff;
	localparam logic [15:0]           BANK_BASE    = 16'h8000;
	localparam logic [15:0]           RAM_BASE     = 16'hc000;
	localparam logic [7:0]            NO_ROM_BYTE  = 8'hff;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;
	localparam int TUSER_W     = 3;

	// output tdata layout
	localparam int OUT_RD_LSB  = 0;
	localparam int OUT_OFF_LSB = 8;
	localparam int OUT_REG_LSB = 28;
	localparam int OUT_CD_LSB  = 30;
	localparam int OUT_NMI_BIT = 38;
	localparam int OUT_PAD_BIT = 39;

	localparam logic [2:0] CMD_MEM_RD   = 3'd0;
	localparam logic [2:0] CMD_MEM_WR   = 3'd1;
	localparam logic [2:0] CMD_PORT_IN  = 3'd2;
	localparam logic [2:0] CMD_PORT_OUT = 3'd3;
	localparam logic [2:0] CMD_LATCH_WR = 3'd4;
	localparam logic [2:0] CMD_REPLY_RD = 3'd5;

	localparam logic [2:0] KIND_DATA      = 3'd0;
	localparam logic [2:0] KIND_ROM_FETCH = 3'd1;
	localparam logic [2:0] KIND_CHIP_RD   = 3'd2;
	localparam logic [2:0] KIND_CHIP_WR   = 3'd3;
	localparam logic [2:0] KIND_DONE      = 3'd4;

	localparam logic [7:0] PORT_LATCH   = 8'h00;
	localparam logic [7:0] PORT_REPLY   = 8'h0c;
	localparam logic [7:0] PORT_NMI_OFF = 8'h18;
	localparam logic [3:0] NIB_BANK     = 4'h8;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_RAM_RD,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [LIN_W-1:0]      dividend;
		logic [ROM_SIZE_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic                done;
		logic [OFFSET_W-1:0] remainder;
	} mod_rsp_t;

endpackage

`default_nettype wire

@@ rtl/scbc_mod_unit.sv @@
// ----------------------------------------------------------------------------
// scbc_mod_unit
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scbc_mod_unit (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire scbc_pkg::mod_req_t   req,
	output scbc_pkg::mod_rsp_t        rsp
);
	import scbc_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [LIN_W-1:0]      dvd_q;
	logic [ROM_SIZE_W-1:0] div_q;
	logic [ROM_SIZE_W-1:0] rem_q;
	logic [ROM_SIZE_W:0]   trial;
	logic [ROM_SIZE_W:0]   rem_next;

	assign trial    = {rem_q, dvd_q[LIN_W-1]};
	assign rem_next = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(LIN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[LIN_W-2:0], 1'b0};
			rem_q <= rem_next[ROM_SIZE_W-1:0];
		end
	end

	assign rsp = {done_q, rem_q[OFFSET_W-1:0]};

endmodule

`default_nettype wire

@@ rtl/scbc_work_ram.sv @@
// ----------------------------------------------------------------------------
// scbc_work_ram
// single port work ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scbc_work_ram (
	input  wire                       clk,
	input  wire                       we,
	input  wire [scbc_pkg::RAM_AW-1:0] addr,
	input  wire [7:0]                 wdata,
	output logic [7:0]                rdata
);
	import scbc_pkg::*;

	logic [7:0] mem [RAM_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

@@ rtl/sound_cpu_bus_controller.sv @@
// ----------------------------------------------------------------------------
// sound_cpu_bus_controller
// rom fetch: accept, exec, then the remainder unit taking one linear address
//   bit per cycle (18 bits), then emit into the output register
// ram read: accept, exec, ram read, emit; all other accesses: accept, exec, emit
// one item at a time, the next taken only after emit; output stalls hold emit
// reset: ram clearing sweep over all 8192 bytes after reset, no item accepted then
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sound_cpu_bus_controller (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_wr_en,
	input  wire [scbc_pkg::ROM_SIZE_W-1:0]      cfg_wr_data,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// address[15:0], write_data[23:16]
	input  wire [scbc_pkg::IN_TDATA_W-1:0]      s_tdata,
	// command[2:0]
	input  wire [scbc_pkg::TUSER_W-1:0]         s_tuser,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// read_data[7:0], rom_offset[27:8], chip_register[29:28],
	// chip_data[37:30], nmi_pulse[38], zero[39]
	output logic [scbc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// kind[2:0]
	output logic [scbc_pkg::TUSER_W-1:0]        m_tuser
);
	import scbc_pkg::*;

	state_t state_q, state_d;

	logic [RAM_AW-1:0]     clr_cnt_q;
	logic [ROM_SIZE_W-1:0] rom_size_q;
	logic [3:0]            bank_q;
	logic                  nmi_en_q;
	logic [7:0]            latch_q;
	logic [7:0]            reply_q;

	logic [2:0]            cmd_q;
	logic [15:0]           addr_q;
	logic [7:0]            wdata_q;

	logic [2:0]            res_kind_q;
	logic [7:0]            res_rd_q;
	logic [OFFSET_W-1:0]   res_off_q;
	logic [1:0]            res_reg_q;
	logic [7:0]            res_cd_q;
	logic                  res_nmi_q;

	logic                  out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [TUSER_W-1:0]    out_kind_q;

	logic                  ram_we;
	logic [RAM_AW-1:0]     ram_addr;
	logic [7:0]            ram_wdata;
	logic [7:0]            ram_rdata;

	mod_req_t              mod_req;
	mod_rsp_t              mod_rsp;

	logic [ROM_SIZE_W-1:0] size_c;
	logic                  is_rom;
	logic [LIN_W-1:0]      linear;
	logic [7:0]            low;
	logic                  out_free;

	assign size_c   = (rom_size_q > ROM_SIZE_MAX) ? ROM_SIZE_MAX : rom_size_q;
	assign is_rom   = (addr_q < RAM_BASE);
	assign linear   = (addr_q < BANK_BASE) ? LIN_W'(addr_q[14:0]) :
		LIN_W'(bank_q * BANK_BYTES) + LIN_W'(addr_q[13:0]);
	assign low      = addr_q[7:0];
	assign out_free = !out_valid_q || m_tready;

	scbc_work_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	scbc_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		s_tready         = 1'b0;
		ram_we           = 1'b0;
		ram_addr         = RAM_AW'(addr_q & RAM_MASK);
		ram_wdata        = wdata_q;
		mod_req.start    = 1'b0;
		mod_req.dividend = linear;
		mod_req.divisor  = size_c;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_cnt_q;
				ram_wdata = '0;
				if (clr_cnt_q == RAM_AW'(RAM_BYTES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_EMIT;
				if (cmd_q == CMD_MEM_RD) begin
					if (!is_rom) begin
						state_d = ST_RAM_RD;
					end else if (size_c != '0) begin
						mod_req.start = 1'b1;
						state_d       = ST_DIV;
					end
				end else if (cmd_q == CMD_MEM_WR && !is_rom) begin
					ram_we = 1'b1;
				end
			end
			ST_RAM_RD: begin
				state_d = ST_EMIT;
			end
			ST_DIV: begin
				if (mod_rsp.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			rom_size_q  <= '0;
			bank_q      <= '0;
			nmi_en_q    <= 1'b0;
			latch_q     <= '0;
			reply_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cfg_wr_en) begin
				rom_size_q <= cfg_wr_data;
			end
			if (state_q == ST_EXEC) begin
				case (cmd_q)
					CMD_PORT_OUT: begin
						if (low[7:2] == 6'b000010) begin
							nmi_en_q <= 1'b1;
							bank_q   <= addr_q[11:8];
						end else if (low == PORT_REPLY) begin
							reply_q <= wdata_q;
						end else if (low == PORT_NMI_OFF) begin
							nmi_en_q <= 1'b0;
						end else if (low[7:4] != 4'h0 && low[3:0] == NIB_BANK) begin
							bank_q <= low[7:4];
						end
					end
					CMD_LATCH_WR: begin
						latch_q <= wdata_q;
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			cmd_q   <= s_tuser;
			addr_q  <= s_tdata[15:0];
			wdata_q <= s_tdata[23:16];
		end
		if (state_q == ST_EXEC) begin
			res_kind_q <= KIND_DONE;
			res_rd_q   <= '0;
			res_off_q  <= '0;
			res_reg_q  <= '0;
			res_cd_q   <= '0;
			res_nmi_q  <= 1'b0;
			case (cmd_q)
				CMD_MEM_RD: begin
					if (!is_rom) begin
						res_kind_q <= KIND_DATA;
					end else if (size_c == '0) begin
						res_kind_q <= KIND_DATA;
						res_rd_q   <= NO_ROM_BYTE;
					end else begin
						res_kind_q <= KIND_ROM_FETCH;
					end
				end
				CMD_PORT_IN: begin
					res_kind_q <= KIND_DATA;
					if (low == PORT_LATCH) begin
						res_rd_q <= latch_q;
					end else if (low[7:2] == 6'b000001) begin
						res_kind_q <= KIND_CHIP_RD;
						res_reg_q  <= low[1:0];
					end
				end
				CMD_PORT_OUT: begin
					if (low[7:2] == 6'b000001) begin
						res_kind_q <= KIND_CHIP_WR;
						res_reg_q  <= low[1:0];
						res_cd_q   <= wdata_q;
					end
				end
				CMD_LATCH_WR: begin
					res_nmi_q <= nmi_en_q;
				end
				CMD_REPLY_RD: begin
					res_kind_q <= KIND_DATA;
					res_rd_q   <= reply_q;
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_RAM_RD) begin
			res_rd_q <= ram_rdata;
		end
		if (state_q == ST_DIV && mod_rsp.done) begin
			res_off_q <= mod_rsp.remainder;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_kind_q <= res_kind_q;
			out_data_q <= {1'b0, res_nmi_q, res_cd_q, res_reg_q, res_off_q, res_rd_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;

endmodule

`default_nettype wire

@@ rtl/scbc_checker.sv @@
// ----------------------------------------------------------------------------
// scbc_checker
// port level checks on the sound cpu bus controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sound_cpu_bus_controller_defines.svh"

module scbc_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              s_tvalid,
	input wire                              s_tready,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [scbc_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input wire [scbc_pkg::TUSER_W-1:0]      m_tuser
);
	import scbc_pkg::*;

	`SCBC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled item changed")
	`SCBC_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "item accepted while busy")
	`SCBC_ASSERT_NOW(a_data_only_kind0, m_tvalid && m_tuser != KIND_DATA, m_tdata[OUT_OFF_LSB-1:OUT_RD_LSB] == 8'h00, "read byte outside data kind")
	`SCBC_ASSERT_NOW(a_nmi_done, m_tvalid && m_tdata[OUT_NMI_BIT], m_tuser == KIND_DONE && !m_tdata[OUT_PAD_BIT], "nmi pulse on wrong kind")

endmodule

bind sound_cpu_bus_controller scbc_checker u_scbc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
